/* rtl/core/bba_pkg.sv */
// Shared constants, types and helpers of the bitmap block allocator.
// Used by the bitmap RAM and by the top level; no dependencies.
package bba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int ROW_W      = 32;
  localparam int NUM_ROWS   = NUM_BLOCKS / ROW_W;
  localparam int ROW_AW     = $clog2(NUM_ROWS);
  localparam int BIT_AW     = $clog2(ROW_W);
  localparam int BLK_AW     = ROW_AW + BIT_AW;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_W      = 9;
  localparam int RSV_W      = 9;

  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [ROW_AW-1:0]   row_addr_t;
  typedef logic [BIT_AW-1:0]   bit_pos_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_FORMAT  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // lowest clear bit of a bitmap row
  function automatic bit_pos_t ffz_row(input row_t w);
    bit_pos_t pos;
    pos = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!w[i]) pos = bit_pos_t'(i);
    end
    return pos;
  endfunction

  // lowest row whose full flag is clear
  function automatic row_addr_t ffz_flags(input logic [NUM_ROWS-1:0] f);
    row_addr_t pos;
    pos = '0;
    for (int i = NUM_ROWS - 1; i >= 0; i--) begin
      if (!f[i]) pos = row_addr_t'(i);
    end
    return pos;
  endfunction

endpackage

/* rtl/core/bitmap_block_allocator_unit.sv */
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg and bba_bitmap_ram.
//
// Usage
//   Request beats enter on in_* (in_tuser = opcode, in_tdata = block index);
//   each request yields exactly one result beat on out_* (out_tuser = status,
//   out_tdata = granted block and free count). reserved_blocks is written
//   over the cfg_* APB port at address 0 while the unit is idle.
// Sequencing
//   One request at a time. Allocate and release read one bitmap row and
//   write it back (release only when the bit was set), then go to DONE.
//   Format sweeps every row, one per cycle, then goes to DONE. Full,
//   out-of-range and unused-opcode requests go straight to DONE. Per-row
//   full flags in flops pick the row to read directly, so an allocate never
//   scans the bitmap.
// Reset
//   Synchronous, active low. All blocks free, count = NUM_BLOCKS,
//   reserved_blocks = 0. Row valid flags in the RAM stand in for clearing it.
// Backpressure
//   The result sits in an output register; the next request is accepted
//   while it waits. A finished result that finds the register still full
//   holds in DONE until out_tready frees it.
module bitmap_block_allocator_unit
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [8:0] block_index, [15:9] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] granted_block, [16:8] free_count, [23:17] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FMT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [2:0] ADDR_RSV = 3'd0;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  row_addr_t           row_r, row_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [BLK_AW-1:0]   res_grant_r, res_grant_nxt;
  cnt_t                free_cnt_r, free_cnt_nxt;
  logic [NUM_ROWS-1:0] row_full_r, row_full_nxt;
  logic [RSV_W-1:0]    rsv_r;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [BLK_AW-1:0]   out_grant_r;
  cnt_t                out_cnt_r;

  // bitmap RAM side
  logic      ram_we;
  row_addr_t ram_waddr, ram_raddr;
  row_t      ram_wdata, ram_rdata;

  logic      in_acc, out_load, cfg_wr;
  cnt_t      fmt_n;
  cnt_t      row_base, row_top;
  row_t      fmt_row, bit_mask;
  bit_pos_t  pos;

  bba_bitmap_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // format: blocks below min(reserved_blocks, NUM_BLOCKS) are used
  assign fmt_n    = (rsv_r > RSV_W'(NUM_BLOCKS)) ? cnt_t'(NUM_BLOCKS) : cnt_t'(rsv_r);
  assign row_base = cnt_t'({row_r, {BIT_AW{1'b0}}});
  assign row_top  = row_base + cnt_t'(ROW_W);

  always_comb begin
    priority if (fmt_n >= row_top) begin
      fmt_row = '1;
    end else if (fmt_n <= row_base) begin
      fmt_row = '0;
    end else begin
      fmt_row = ~(row_t'('1) << bit_pos_t'(fmt_n - row_base));
    end
  end

  // alloc picks the lowest clear bit, release the named one
  assign pos      = (op_r == OP_ALLOC) ? ffz_row(ram_rdata) : idx_r[BIT_AW-1:0];
  assign bit_mask = row_t'(1) << pos;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    row_nxt        = row_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    free_cnt_nxt   = free_cnt_r;
    row_full_nxt   = row_full_r;
    ram_we         = 1'b0;
    ram_waddr      = row_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = row_r;

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = (in_tuser == OP_ALLOC) ? ffz_flags(row_full_r)
                                           : in_tdata[BLK_AW-1:BIT_AW];
        if (in_acc) begin
          op_nxt         = in_tuser;
          idx_nxt        = in_tdata[IDX_W-1:0];
          row_nxt        = ram_raddr;
          res_status_nxt = ST_DONE;
          res_grant_nxt  = '0;
          unique case (in_tuser)
            OP_ALLOC: begin
              if (free_cnt_r == '0) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_RELEASE: begin
              if (in_tdata[IDX_W-1:BLK_AW] != '0) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_FORMAT: begin
              row_nxt   = '0;
              state_nxt = S_FMT;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_READ: begin
        if (op_r == OP_ALLOC) begin
          ram_we                = 1'b1;
          ram_wdata             = ram_rdata | bit_mask;
          res_grant_nxt         = {row_r, pos};
          free_cnt_nxt          = free_cnt_r - cnt_t'(1);
          row_full_nxt[row_r]   = &ram_wdata;
        end else if ((ram_rdata & bit_mask) != '0) begin
          ram_we                = 1'b1;
          ram_wdata             = ram_rdata & ~bit_mask;
          free_cnt_nxt          = free_cnt_r + cnt_t'(1);
          row_full_nxt[row_r]   = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_FMT: begin
        ram_we              = 1'b1;
        ram_wdata           = fmt_row;
        row_full_nxt[row_r] = &fmt_row;
        row_nxt             = row_r + row_addr_t'(1);
        if (row_r == row_addr_t'(NUM_ROWS - 1)) begin
          free_cnt_nxt = cnt_t'(NUM_BLOCKS) - fmt_n;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // APB register: write on access phase, reads are combinational
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_RSV) ? {{(32-RSV_W){1'b0}}, rsv_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= cnt_t'(NUM_BLOCKS);
      row_full_r  <= '0;
      rsv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      row_full_r  <= row_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_paddr == ADDR_RSV) begin
        rsv_r <= cfg_pwdata[RSV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    row_r        <= row_nxt;
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
      out_cnt_r    <= free_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(24-CNT_W-BLK_AW){1'b0}}, out_cnt_r, out_grant_r};

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= cnt_t'(NUM_BLOCKS))
    else $error("free count above block total");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_cnt_r == '0)
    else $error("full reported with free blocks left");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_DONE |-> out_grant_r == '0)
    else $error("grant set on failed request");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_tready |=> state_r == S_DONE)
    else $error("result dropped while output stalled");

  a_alloc_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ && op_r == OP_ALLOC |-> !(&ram_rdata))
    else $error("allocate read a full row");
`endif

endmodule

/* rtl/core/bba_bitmap_ram.sv */
// Bitmap storage: one row of ROW_W used/free bits per address, registered read.
// Per-row valid flags make never-written rows read as all free after reset.
// Depends on bba_pkg.
module bba_bitmap_ram
  import bba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      we,
  input  row_addr_t waddr,
  input  row_t      wdata,
  input  row_addr_t raddr,
  output row_t      rdata
);

  row_t                mem [NUM_ROWS];
  row_t                q_r;
  logic                q_vld_r;
  logic [NUM_ROWS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      q_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

/* dv/bitmap_allocator_checker.sv */
`timescale 1ns / 100ps
// Checker for bitmap_block_allocator_unit: watches the request, result and cfg ports,
// predicts each result from its own copy of the map, and counts failures.
// Depends on bba_pkg.
module bitmap_allocator_checker
  import bba_pkg::*;
#(
  parameter logic [2:0] RSV_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [8:0] block_index, [15:9] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] granted_block, [16:8] free_count, [23:17] zero
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          results_pending
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted;
    cnt_t       free_count;
  } alloc_result_t;

  logic [NUM_BLOCKS-1:0] used_map;
  cnt_t                  free_tally;
  logic [RSV_W-1:0]      reserved_setting;
  alloc_result_t         results_due[$];
  int                    fails = 0;
  int                    results_seen = 0;

  task automatic log_failure(input string text);
    fails++;
    if (fails <= 10) $display("%s", text);
  endtask

  // Applies one request to the local map and returns the result it should give.
  function automatic alloc_result_t predict_request(input logic [1:0] op,
                                                    input logic [IDX_W-1:0] idx);
    alloc_result_t r;
    int            span;
    bit            hit;
    r.status  = ST_DONE;
    r.granted = '0;
    hit       = 1'b0;
    if (op == OP_ALLOC) begin
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        if (!hit && !used_map[b]) begin
          used_map[b] = 1'b1;
          free_tally  = free_tally - 1'b1;
          r.granted   = b[7:0];
          hit         = 1'b1;
        end
      end
      if (!hit) r.status = ST_FULL;
    end else if (op == OP_RELEASE) begin
      if (idx >= NUM_BLOCKS) begin
        r.status = ST_RANGE;
      end else if (used_map[idx]) begin
        used_map[idx] = 1'b0;
        free_tally    = free_tally + 1'b1;
      end
    end else if (op == OP_FORMAT) begin
      // oversized reservation saturates: whole map used
      span     = (reserved_setting > NUM_BLOCKS) ? NUM_BLOCKS : int'(reserved_setting);
      used_map = '0;
      for (int b = 0; b < span; b++) used_map[b] = 1'b1;
      free_tally = cnt_t'(NUM_BLOCKS - span);
    end
    r.free_count = free_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_n) begin
      used_map         = '0;
      free_tally       = cnt_t'(NUM_BLOCKS);
      reserved_setting = '0;
      results_due.delete();
    end else begin
      // results first: a beat leaving now belongs to an earlier request
      if (out_tvalid && out_tready) begin
        got.status     = out_tuser;
        got.granted    = out_tdata[7:0];
        got.free_count = out_tdata[16:8];
        results_seen++;
        if (results_due.size() == 0) begin
          log_failure($sformatf("result %0d with nothing expected: status %0d block %0d free %0d",
                                results_seen, got.status, got.granted, got.free_count));
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.granted !== want.granted ||
              got.free_count !== want.free_count)
            log_failure($sformatf(
              "result %0d: expected status %0d block %0d free %0d, got status %0d block %0d free %0d",
              results_seen, want.status, want.granted, want.free_count,
              got.status, got.granted, got.free_count));
        end
      end
      if (in_tvalid && in_tready)
        results_due.push_back(predict_request(in_tuser, in_tdata[IDX_W-1:0]));
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == RSV_ADDR) begin
        if (cfg_pwrite)
          reserved_setting = cfg_pwdata[RSV_W-1:0];
        else if (cfg_prdata[RSV_W-1:0] !== reserved_setting)
          log_failure($sformatf("reserved_blocks read %0d, expected %0d",
                                cfg_prdata[RSV_W-1:0], reserved_setting));
      end
    end
    fail_count      <= fails;
    results_pending <= results_due.size();
  end

endmodule

/* dv/bitmap_block_allocator_unit_test.sv */
`timescale 1ns / 100ps
// Testbench top for bitmap_block_allocator_unit: clock, reset, request and cfg
// stimulus, result back-pressure, watchdog and verdict.
// Depends on bba_pkg, the unit and bitmap_allocator_checker.
module bitmap_block_allocator_unit_test;
  import bba_pkg::*;

  localparam logic [2:0] RSV_REG_ADDR   = 3'd0;
  localparam logic [2:0] SPARE_REG_ADDR = 3'd4;  // past the register list, writes dropped
  localparam logic [1:0] OP_UNUSED      = 2'd3;

  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 100;
  localparam int LONG_HOLD   = 150;   // receiver hold-off, cycles
  localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles with no beat on any port
  localparam int TAIL_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [8:0] block_index, [15:9] zero
  logic [1:0]  in_tuser;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] granted_block, [16:8] free_count, [23:17] zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int results_pending;

  // knobs shared between the request driver and the result sink
  bit src_gaps     = 1'b1;
  bit sink_stalls  = 1'b1;
  bit hold_results = 1'b0;

  bitmap_block_allocator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bitmap_allocator_checker #(.RSV_ADDR(RSV_REG_ADDR)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request beat and return at the edge that takes it. Valid stays
  // high unless a sender gap follows, so back-to-back beats need no re-raise.
  task automatic offer_request(input logic [1:0] op, input logic [IDX_W-1:0] idx);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  // Called right at an accept edge, so valid drops without a stray beat.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB transfer: setup cycle, access cycle, then a return to idle so psel is
  // never dropped and raised in the same step by back-to-back transfers.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain, write reserved_blocks with junk in the unused upper bits, read it back.
  task automatic set_reserved(input logic [RSV_W-1:0] value);
    logic [31:0] word;
    word             = $urandom();
    word[RSV_W-1:0]  = value;
    settle();
    apb_access(1'b1, RSV_REG_ADDR, word);
    apb_access(1'b0, RSV_REG_ADDR, 32'd0);
  endtask

  // Result sink: random stall bursts, plus one long hold-off on request so
  // the unit backs up and stalls its request side.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run if no beat moves on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Reserve plan per random phase (phases 6 and 10 draw at random): extremes, the
  // saturating range and a few values that leave only a handful of blocks free.
  int unsigned reserve_plan[PHASES] = '{200, 0, 256, 511, 255, 128, 0, 240, 1, 250, 0, 300};

  initial begin : stimulus
    int               alloc_pct;
    int               roll;
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [RSV_W-1:0] rsv;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // fresh map, first fit hands out 0, 1, 2; index field is don't-care here
    offer_request(OP_ALLOC, 9'h000);
    offer_request(OP_ALLOC, 9'h1FF);
    offer_request(OP_ALLOC, 9'h0AA);
    offer_request(OP_RELEASE, 9'd1);
    offer_request(OP_RELEASE, 9'd1);     // already free: no change
    offer_request(OP_ALLOC, 9'h155);     // refills the hole at 1
    offer_request(OP_RELEASE, 9'd255);   // top block, free
    offer_request(OP_RELEASE, 9'd256);   // first out-of-range index
    offer_request(OP_RELEASE, 9'd511);   // last out-of-range index
    offer_request(OP_RELEASE, 9'd0);
    offer_request(OP_UNUSED, 9'h1FF);    // unused opcode: status done, no change

    set_reserved(9'd256);
    offer_request(OP_FORMAT, 9'h0AA);    // whole map used
    offer_request(OP_ALLOC, 9'h155);     // full
    offer_request(OP_RELEASE, 9'd255);
    offer_request(OP_ALLOC, 9'd0);       // gets 255
    offer_request(OP_ALLOC, 9'd0);       // full again

    set_reserved(9'd511);                // saturates at the block count
    offer_request(OP_FORMAT, 9'd0);
    offer_request(OP_ALLOC, 9'd0);

    set_reserved(9'd255);
    offer_request(OP_FORMAT, 9'd0);
    offer_request(OP_ALLOC, 9'd0);       // the single free block, 255

    set_reserved(9'd0);
    settle();
    apb_access(1'b1, SPARE_REG_ADDR, 32'hFFFF_FFFF);  // no such register
    offer_request(OP_FORMAT, 9'd0);      // reserve must still be zero
    offer_request(OP_ALLOC, 9'd0);

    // ---- random part ----
    for (int p = 0; p < PHASES; p++) begin
      // last two phases run with no idling on either side
      src_gaps    = (p < PHASES - 2);
      sink_stalls = (p < PHASES - 2);
      rsv = (p == 6 || p == 10) ? RSV_W'($urandom_range(0, 511)) : RSV_W'(reserve_plan[p]);
      set_reserved(rsv);
      if (p == 1) hold_results = 1'b1;   // sender keeps offering through it
      alloc_pct = (p % 3 == 0) ? 80 : ((p % 3 == 1) ? 45 : 25);
      offer_request(OP_FORMAT, IDX_W'($urandom_range(0, 511)));
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 3 && k == PHASE_BEATS / 2) settle();  // sender pause, unit drains
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)  op = OP_ALLOC;
        else if (roll < 95)    op = OP_RELEASE;
        else if (roll < 98)    op = OP_FORMAT;
        else                   op = OP_UNUSED;
        roll = $urandom_range(0, 99);
        if (op != OP_RELEASE)  idx = IDX_W'($urandom_range(0, 511));
        else if (roll < 8)     idx = IDX_W'($urandom_range(NUM_BLOCKS, 511));
        else if (roll < 60)    idx = IDX_W'($urandom_range(0, 63));   // dense low end
        else                   idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
        offer_request(op, idx);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
